FILE: src/mets_pkg.sv
package mets_pkg;

   localparam int MAX_WIDTH = 1024;
   localparam int MAX_ITER  = 256;

   localparam int IDX_W     = 10;
   localparam int OUT_W     = 8;
   localparam int QW        = 40;                  // Q8.32 value
   localparam int FRAC      = 32;
   localparam int SW        = 51;                  // wide sum / shifted product
   localparam int MW        = 41;                  // multiplier operand magnitude
   localparam int PW        = 83;                  // exact signed product
   localparam int DEPTH_W   = $clog2(MAX_ITER + 1);
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_X_MIN      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_MIN      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_STEP = 2'd2;

   localparam logic signed [SW-1:0] Q_MAX = {{(SW-QW+1){1'b0}}, {(QW-1){1'b1}}};
   localparam logic signed [SW-1:0] Q_MIN = {{(SW-QW+1){1'b1}}, {(QW-1){1'b0}}};
   localparam logic signed [QW-1:0] ESCAPE_LIMIT = 40'sh05_0000_0000;

   typedef logic signed [QW-1:0] q_type;
   typedef logic signed [SW-1:0] wide_type;

   typedef struct packed {
      logic signed [QW-1:0] x_min;
      logic signed [QW-1:0] y_min;
      logic [QW-2:0]        pixel_step;
   } cfg_type;

   typedef struct packed {
      logic          start;
      logic          neg;
      logic [MW-1:0] a_mag;
      logic [MW-1:0] b_mag;
   } mul_cmd_type;

   typedef struct packed {
      logic                 done;
      logic signed [PW-1:0] prod;
   } mul_rsp_type;

   typedef struct packed {
      logic busy;
      logic res_valid;
   } core_status_type;

   function automatic wide_type sx(input q_type v);
      return {{(SW-QW){v[QW-1]}}, v};
   endfunction

   function automatic q_type sat_q(input wide_type v);
      q_type r;
      if (v > Q_MAX) begin
         r = Q_MAX[QW-1:0];
      end else if (v < Q_MIN) begin
         r = Q_MIN[QW-1:0];
      end else begin
         r = v[QW-1:0];
      end
      return r;
   endfunction

   // floor(p / 2^32), saturated
   function automatic q_type prod_q(input logic signed [PW-1:0] p);
      return sat_q(p[PW-1:FRAC]);
   endfunction

   function automatic logic [MW-1:0] mag_of(input logic signed [MW-1:0] v);
      logic signed [MW-1:0] n;
      n = -v;
      return v[MW-1] ? MW'(n) : MW'(v);
   endfunction

endpackage

FILE: src/mets_mul.sv
module mets_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  mets_pkg::mul_cmd_type cmd,
   output mets_pkg::mul_rsp_type rsp
);

   localparam int ACC_W = 2 * mets_pkg::MW;
   localparam int HI_W  = mets_pkg::MW - 32;

   localparam logic [1:0] PP_LL = 2'd0;
   localparam logic [1:0] PP_HL = 2'd1;
   localparam logic [1:0] PP_LH = 2'd2;
   localparam logic [1:0] PP_HH = 2'd3;
   localparam logic [2:0] STEPS = 3'd4;

   logic                          busy_ff, busy_in;
   logic [2:0]                    step_ff, step_in;
   logic                          pp_vld_ff, pp_vld_in;
   logic                          done_ff, done_in;
   logic [mets_pkg::MW-1:0]       a_ff, a_in, b_ff, b_in;
   logic                          neg_ff, neg_in;
   logic [63:0]                   pp_ff, pp_in;
   logic [1:0]                    pp_code_ff, pp_code_in;
   logic [ACC_W-1:0]              acc_ff, acc_in;
   logic signed [mets_pkg::PW-1:0] res_ff, res_in;
   logic [31:0]                   op_a, op_b;
   logic [ACC_W-1:0]              pp_shift;

   // one 32x32 partial product per cycle
   always_comb begin
      unique case (step_ff[1:0])
         PP_LL: begin
            op_a = a_ff[31:0];
            op_b = b_ff[31:0];
         end
         PP_HL: begin
            op_a = 32'(a_ff[mets_pkg::MW-1:32]);
            op_b = b_ff[31:0];
         end
         PP_LH: begin
            op_a = a_ff[31:0];
            op_b = 32'(b_ff[mets_pkg::MW-1:32]);
         end
         PP_HH: begin
            op_a = 32'(a_ff[mets_pkg::MW-1:32]);
            op_b = 32'(b_ff[mets_pkg::MW-1:32]);
         end
      endcase
   end

   always_comb begin
      unique case (pp_code_ff)
         PP_LL:        pp_shift = ACC_W'(pp_ff);
         PP_HL, PP_LH: pp_shift = ACC_W'(pp_ff) << 32;
         PP_HH:        pp_shift = ACC_W'(pp_ff[2*HI_W-1:0]) << 64;
      endcase
   end

   always_comb begin
      busy_in    = busy_ff;
      step_in    = step_ff;
      pp_vld_in  = 1'b0;
      done_in    = 1'b0;
      a_in       = a_ff;
      b_in       = b_ff;
      neg_in     = neg_ff;
      pp_in      = pp_ff;
      pp_code_in = pp_code_ff;
      acc_in     = acc_ff;
      res_in     = res_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         step_in = 3'd0;
         a_in    = cmd.a_mag;
         b_in    = cmd.b_mag;
         neg_in  = cmd.neg;
         acc_in  = '0;
      end else if (busy_ff) begin
         if (step_ff != STEPS) begin
            pp_in      = op_a * op_b;
            pp_code_in = step_ff[1:0];
            pp_vld_in  = 1'b1;
            step_in    = step_ff + 3'd1;
         end
         if (pp_vld_ff) begin
            acc_in = acc_ff + pp_shift;
         end
         if (step_ff == STEPS && !pp_vld_ff) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            res_in  = neg_ff ? -$signed({1'b0, acc_ff}) : $signed({1'b0, acc_ff});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         step_ff   <= 3'd0;
         pp_vld_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         step_ff   <= step_in;
         pp_vld_ff <= pp_vld_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff       <= a_in;
      b_ff       <= b_in;
      neg_ff     <= neg_in;
      pp_ff      <= pp_in;
      pp_code_ff <= pp_code_in;
      acc_ff     <= acc_in;
      res_ff     <= res_in;
   end

   assign rsp.done = done_ff;
   assign rsp.prod = res_ff;

endmodule

FILE: src/mets_core.sv
module mets_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [mets_pkg::IDX_W-1:0]      pixel_row,
   input  logic [mets_pkg::IDX_W-1:0]      pixel_col,
   input  mets_pkg::cfg_type               cfg,
   input  logic                            take,
   output mets_pkg::core_status_type       status,
   output logic [mets_pkg::OUT_W-1:0]      remaining_depth
);

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_CX_ISS  = 4'd1;
   localparam logic [3:0] ST_CX_WAIT = 4'd2;
   localparam logic [3:0] ST_CY_ISS  = 4'd3;
   localparam logic [3:0] ST_CY_WAIT = 4'd4;
   localparam logic [3:0] ST_X2_ISS  = 4'd5;
   localparam logic [3:0] ST_X2_WAIT = 4'd6;
   localparam logic [3:0] ST_Y2_ISS  = 4'd7;
   localparam logic [3:0] ST_Y2_WAIT = 4'd8;
   localparam logic [3:0] ST_XY_ISS  = 4'd9;
   localparam logic [3:0] ST_XY_WAIT = 4'd10;
   localparam logic [3:0] ST_UPD1    = 4'd11;
   localparam logic [3:0] ST_UPD2    = 4'd12;
   localparam logic [3:0] ST_DONE    = 4'd13;

   logic [3:0]                       state_ff, state_in;
   logic [mets_pkg::IDX_W-1:0]       row_ff, row_in, col_ff, col_in;
   mets_pkg::q_type                  cx_ff, cx_in, cy_ff, cy_in;
   mets_pkg::q_type                  x_ff, x_in, y_ff, y_in;
   mets_pkg::q_type                  x2_ff, x2_in, y2_ff, y2_in, xy_ff, xy_in, t_ff, t_in;
   logic                             esc_ff, esc_in;
   logic [mets_pkg::DEPTH_W-1:0]     depth_ff, depth_in;
   mets_pkg::q_type                  mag;
   mets_pkg::wide_type               c_sum;
   mets_pkg::mul_cmd_type            mul_cmd;
   mets_pkg::mul_rsp_type            mul_rsp;

   mets_mul u_mul (
      .clock (clock),
      .reset (reset),
      .cmd   (mul_cmd),
      .rsp   (mul_rsp)
   );

   always_comb begin
      mul_cmd.start = 1'b0;
      mul_cmd.neg   = 1'b0;
      mul_cmd.a_mag = '0;
      mul_cmd.b_mag = '0;
      unique case (state_ff)
         ST_CX_ISS: begin
            mul_cmd.start = 1'b1;
            mul_cmd.a_mag = mets_pkg::MW'(col_ff);
            mul_cmd.b_mag = mets_pkg::MW'(cfg.pixel_step);
         end
         ST_CY_ISS: begin
            mul_cmd.start = 1'b1;
            mul_cmd.a_mag = mets_pkg::MW'(row_ff);
            mul_cmd.b_mag = mets_pkg::MW'(cfg.pixel_step);
         end
         ST_X2_ISS: begin
            mul_cmd.start = 1'b1;
            mul_cmd.a_mag = mets_pkg::mag_of({x_ff[mets_pkg::QW-1], x_ff});
            mul_cmd.b_mag = mets_pkg::mag_of({x_ff[mets_pkg::QW-1], x_ff});
         end
         ST_Y2_ISS: begin
            mul_cmd.start = 1'b1;
            mul_cmd.a_mag = mets_pkg::mag_of({y_ff[mets_pkg::QW-1], y_ff});
            mul_cmd.b_mag = mets_pkg::mag_of({y_ff[mets_pkg::QW-1], y_ff});
         end
         ST_XY_ISS: begin
            // operand is 2x, exact in 41 bits
            mul_cmd.start = 1'b1;
            mul_cmd.neg   = x_ff[mets_pkg::QW-1] ^ y_ff[mets_pkg::QW-1];
            mul_cmd.a_mag = mets_pkg::mag_of({x_ff, 1'b0});
            mul_cmd.b_mag = mets_pkg::mag_of({y_ff[mets_pkg::QW-1], y_ff});
         end
         default: begin
         end
      endcase
   end

   // coordinate products are small and non-negative
   assign c_sum = mul_rsp.prod[mets_pkg::SW-1:0];
   assign mag   = mets_pkg::sat_q(mets_pkg::sx(x2_ff) + mets_pkg::sx(y2_ff));

   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      x2_in    = x2_ff;
      y2_in    = y2_ff;
      xy_in    = xy_ff;
      t_in     = t_ff;
      esc_in   = esc_ff;
      depth_in = depth_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               row_in   = (32'(pixel_row) >= mets_pkg::MAX_WIDTH) ?
                          mets_pkg::IDX_W'(mets_pkg::MAX_WIDTH - 1) : pixel_row;
               col_in   = (32'(pixel_col) >= mets_pkg::MAX_WIDTH) ?
                          mets_pkg::IDX_W'(mets_pkg::MAX_WIDTH - 1) : pixel_col;
               state_in = ST_CX_ISS;
            end
         end
         ST_CX_ISS: state_in = ST_CX_WAIT;
         ST_CX_WAIT: begin
            if (mul_rsp.done) begin
               cx_in    = mets_pkg::sat_q(mets_pkg::sx(cfg.x_min) + c_sum);
               state_in = ST_CY_ISS;
            end
         end
         ST_CY_ISS: state_in = ST_CY_WAIT;
         ST_CY_WAIT: begin
            if (mul_rsp.done) begin
               cy_in    = mets_pkg::sat_q(mets_pkg::sx(cfg.y_min) + c_sum);
               x_in     = cx_ff;
               y_in     = mets_pkg::sat_q(mets_pkg::sx(cfg.y_min) + c_sum);
               depth_in = mets_pkg::DEPTH_W'(mets_pkg::MAX_ITER);
               state_in = ST_X2_ISS;
            end
         end
         ST_X2_ISS: state_in = ST_X2_WAIT;
         ST_X2_WAIT: begin
            if (mul_rsp.done) begin
               x2_in    = mets_pkg::prod_q(mul_rsp.prod);
               state_in = ST_Y2_ISS;
            end
         end
         ST_Y2_ISS: state_in = ST_Y2_WAIT;
         ST_Y2_WAIT: begin
            if (mul_rsp.done) begin
               y2_in    = mets_pkg::prod_q(mul_rsp.prod);
               state_in = ST_XY_ISS;
            end
         end
         ST_XY_ISS: state_in = ST_XY_WAIT;
         ST_XY_WAIT: begin
            if (mul_rsp.done) begin
               xy_in    = mets_pkg::prod_q(mul_rsp.prod);
               state_in = ST_UPD1;
            end
         end
         ST_UPD1: begin
            esc_in   = !(mag < mets_pkg::ESCAPE_LIMIT);
            y_in     = mets_pkg::sat_q(mets_pkg::sx(xy_ff) + mets_pkg::sx(cy_ff));
            t_in     = mets_pkg::sat_q(mets_pkg::sx(x2_ff) - mets_pkg::sx(y2_ff));
            state_in = ST_UPD2;
         end
         ST_UPD2: begin
            x_in     = mets_pkg::sat_q(mets_pkg::sx(t_ff) + mets_pkg::sx(cx_ff));
            depth_in = depth_ff - mets_pkg::DEPTH_W'(1);
            // stop once the count would reach zero or the point escaped
            if (depth_ff != mets_pkg::DEPTH_W'(1) && !esc_ff) begin
               state_in = ST_X2_ISS;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff   <= row_in;
      col_ff   <= col_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      x2_ff    <= x2_in;
      y2_ff    <= y2_in;
      xy_ff    <= xy_in;
      t_ff     <= t_in;
      esc_ff   <= esc_in;
      depth_ff <= depth_in;
   end

   assign status.busy      = (state_ff != ST_IDLE);
   assign status.res_valid = (state_ff == ST_DONE);
   assign remaining_depth  = (32'(depth_ff) > 32'd255) ? 8'hFF : 8'(depth_ff);

endmodule

FILE: src/mandelbrot_escape_time_pixel_unit.sv
// Mandelbrot escape-time engine for one pixel at a time.
// Program x_min, y_min and pixel_step through the csr_ port (index 0, 1, 2;
// other indexes are ignored, csr_ready is always high) while the unit is idle.
// A transaction on req_ carries a pixel row and column; the unit forms
// c = (x_min + col*step, y_min + row*step) in Q8.32 and iterates z = z^2 + c,
// returning on rsp_ the iteration count left when |z|^2 reached 5 or 0.
// All multiplies run through one 32x32 multiplier, four partial products per
// Q8.32 product: two products form c, and each iteration takes three
// products plus the two update states.
// One pixel is in flight at a time; req_stall is high from the cycle after
// an accept until the result moves into the output register. A finished
// result waits in that register while rsp_stall is high, and the next pixel
// may be accepted and computed meanwhile; a second result then holds in the
// engine until the register frees up.
// Synchronous reset clears the handshake state and all three registers to 0.
module mandelbrot_escape_time_pixel_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [mets_pkg::IDX_W-1:0]          req_pixel_row,
   input  logic [mets_pkg::IDX_W-1:0]          req_pixel_col,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [mets_pkg::OUT_W-1:0]          rsp_remaining_depth,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mets_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mets_pkg::QW-1:0]             csr_wdata
);

   mets_pkg::cfg_type               cfg_ff, cfg_in;
   mets_pkg::core_status_type       status;
   logic [mets_pkg::OUT_W-1:0]      core_depth;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [mets_pkg::OUT_W-1:0]      rsp_depth_ff, rsp_depth_in;
   logic                            take;
   logic                            accept;

   assign accept    = req_valid && !req_stall;
   assign req_stall = status.busy;
   assign csr_ready = 1'b1;
   assign take      = !rsp_valid_ff || !rsp_stall;

   mets_core u_core (
      .clock           (clock),
      .reset           (reset),
      .start           (accept),
      .pixel_row       (req_pixel_row),
      .pixel_col       (req_pixel_col),
      .cfg             (cfg_ff),
      .take            (take),
      .status          (status),
      .remaining_depth (core_depth)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            mets_pkg::CSR_X_MIN:      cfg_in.x_min      = csr_wdata;
            mets_pkg::CSR_Y_MIN:      cfg_in.y_min      = csr_wdata;
            mets_pkg::CSR_PIXEL_STEP: cfg_in.pixel_step = csr_wdata[mets_pkg::QW-2:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_depth_in = rsp_depth_ff;
      if (take) begin
         rsp_valid_in = status.res_valid;
         if (status.res_valid) begin
            rsp_depth_in = core_depth;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_depth_ff <= rsp_depth_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_remaining_depth = rsp_depth_ff;

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("engine not busy after accepting a pixel");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (status.res_valid && rsp_valid_ff && rsp_stall) |=> status.res_valid)
      else $error("engine result lost while output register was full");

   a_output_drains: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_stall && !status.res_valid) |=> !rsp_valid_ff)
      else $error("output register kept a result after it was taken");
`endif

endmodule
